### sv/vbe_pkg.sv
// vbe_pkg: shared types and constants for the varint byte encoder.
// Depends on nothing; every other file of the encoder imports it.
package vbe_pkg;

   localparam int VALUE_W     = 64;
   localparam int SPACE_W     = 13;
   localparam int CNT_W       = 4;   // holds a byte count up to MAX_BYTES
   localparam int MAX_BYTES   = 10;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] GROUP7_MASK = 8'd127;
   localparam logic [7:0] GROUP6_MASK = 8'd63;
   localparam logic [7:0] SIGN_BIT    = 8'(1 << 6);

   localparam logic MODE_UNSIGNED = 1'b0;
   localparam logic MODE_SIGNED   = 1'b1;

   typedef struct packed {
      logic                 req_type;
      logic [VALUE_W-1:0]   value;
      logic [SPACE_W-1:0]   space_left;
   } vbe_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
      logic       overflow;
   } vbe_rsp_type;

   // classified item handed from the front to the back
   typedef struct packed {
      logic                 mode;
      logic                 sign;
      logic [VALUE_W-1:0]   mag;
      logic [CNT_W-1:0]     nbytes;   // length of the full code
      logic [CNT_W-1:0]     emit;     // bytes that fit in the free space
      logic                 ovf;      // error word follows the emitted bytes
   } vbe_job_type;

endpackage

### sv/varint_byte_encoder.sv
// varint_byte_encoder: top level of the LEB128-style varint encoder.
// Depends on vbe_pkg, vbe_front, vbe_queue and vbe_back.
//
//   channel   dir   word           handshake
//   req_      in    vbe_req_type   req_valid / req_stall
//   rsp_      out   vbe_rsp_type   rsp_valid / rsp_stall
//
// An item is first loaded into the back end, then its result words leave one
// word a cycle while the output is not stalled: the code bytes, or the bytes
// that fit and then the error word when the free space runs out. The byte
// shifter in the back end sets that rate; it takes no new item until done.
// The front classifies in the cycle of acceptance and parks the item in a
// QUEUE_DEPTH-entry queue, so new words are taken while the back end works.
// Reset (synchronous, active high) empties the queue and drops any result.
// A stalled result holds in the output register; the queue absorbs requests
// until it fills, then req_stall rises.
module varint_byte_encoder #(
   parameter int QUEUE_DEPTH = vbe_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  vbe_pkg::vbe_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output vbe_pkg::vbe_rsp_type rsp_data
);
   import vbe_pkg::*;

   vbe_job_type push_job;
   vbe_job_type pop_job;
   logic        pop_valid;
   logic        pop_stall;

   // classify the incoming word: sign, magnitude, code length, fit
   vbe_front u_front (
      .req_data (req_data),
      .job      (push_job)
   );

   // decouple acceptance from byte emission
   vbe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_stall (req_stall),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_stall  (pop_stall),
      .pop_job    (pop_job)
   );

   // emit bytes low group first, then the error word if space ran out
   vbe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_stall (pop_stall),
      .pop_job   (pop_job),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

### sv/vbe_front.sv
// vbe_front: classifies a request word into sign, magnitude and byte counts.
// Depends on vbe_pkg; feeds vbe_queue.
module vbe_front (
   input  vbe_pkg::vbe_req_type req_data,
   output vbe_pkg::vbe_job_type job
);
   import vbe_pkg::*;

   logic               neg;
   logic [VALUE_W-1:0] mag;
   logic [CNT_W-1:0]   nbytes;
   logic [SPACE_W-1:0] nbytes_wide;

   assign neg = (req_data.req_type == MODE_SIGNED) && req_data.value[VALUE_W-1];
   assign mag = neg ? (~req_data.value + VALUE_W'(1)) : req_data.value;

   // each extra byte exists when bits remain above the groups already taken
   always_comb begin
      nbytes = CNT_W'(1);
      for (int k = 1; k < MAX_BYTES; k++) begin
         if (req_data.req_type == MODE_SIGNED) begin
            if ((mag >> (6 + 7 * (k - 1))) != '0) nbytes = nbytes + CNT_W'(1);
         end else begin
            if ((mag >> (7 * k)) != '0) nbytes = nbytes + CNT_W'(1);
         end
      end
   end

   assign nbytes_wide = SPACE_W'(nbytes);

   always_comb begin
      job.mode   = req_data.req_type;
      job.sign   = neg;
      job.mag    = mag;
      job.nbytes = nbytes;
      job.ovf    = nbytes_wide > req_data.space_left;
      job.emit   = job.ovf ? req_data.space_left[CNT_W-1:0] : nbytes;
   end

endmodule

### sv/vbe_queue.sv
// vbe_queue: short FIFO of classified items between front and back.
// Depends on vbe_pkg for the item type.
module vbe_queue #(
   parameter int DEPTH = vbe_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_stall,
   input  vbe_pkg::vbe_job_type push_job,
   output logic                 pop_valid,
   input  logic                 pop_stall,
   output vbe_pkg::vbe_job_type pop_job
);
   import vbe_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_W = $clog2(DEPTH + 1);

   vbe_job_type       slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              push, pop;

   assign push_stall = (fill_ff == FILL_W'(DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_job    = slot_ff[rd_ptr_ff];
   assign push       = push_valid && !push_stall;
   assign pop        = pop_valid && !pop_stall;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) fill_in = fill_ff + FILL_W'(1);
      else if (pop && !push) fill_in = fill_ff - FILL_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_job;
   end

endmodule

### sv/vbe_back.sv
// vbe_back: shifts one classified item out as code bytes plus any error word, one word a cycle unless stalled.
// Depends on vbe_pkg; drains vbe_queue and owns the result register.
module vbe_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   output logic                 pop_stall,
   input  vbe_pkg::vbe_job_type pop_job,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output vbe_pkg::vbe_rsp_type rsp_data
);
   import vbe_pkg::*;

   logic               active_ff, active_in;
   logic               first_ff, first_in;
   logic               mode_ff, mode_in;
   logic               sign_ff, sign_in;
   logic               ovf_ff, ovf_in;
   logic [VALUE_W-1:0] mag_ff, mag_in;
   logic [CNT_W-1:0]   tot_left_ff, tot_left_in;
   logic [CNT_W-1:0]   emit_left_ff, emit_left_in;
   logic               rsp_valid_ff, rsp_valid_in;
   vbe_rsp_type        rsp_ff, rsp_in;
   logic               adv;
   logic               more;
   logic               byte_last;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign pop_stall = active_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign more      = tot_left_ff > CNT_W'(1);
   assign byte_last = (emit_left_ff == CNT_W'(1)) && !ovf_ff;

   always_comb begin
      active_in    = active_ff;
      first_in     = first_ff;
      mode_in      = mode_ff;
      sign_in      = sign_ff;
      ovf_in       = ovf_ff;
      mag_in       = mag_ff;
      tot_left_in  = tot_left_ff;
      emit_left_in = emit_left_ff;
      rsp_valid_in = adv ? 1'b0 : rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (!active_ff) begin
         if (pop_valid) begin
            active_in    = 1'b1;
            first_in     = 1'b1;
            mode_in      = pop_job.mode;
            sign_in      = pop_job.sign;
            ovf_in       = pop_job.ovf;
            mag_in       = pop_job.mag;
            tot_left_in  = pop_job.nbytes;
            emit_left_in = pop_job.emit;
         end
      end else if (adv) begin
         rsp_valid_in = 1'b1;
         if (emit_left_ff != '0) begin
            if (first_ff && (mode_ff == MODE_SIGNED)) begin
               rsp_in.out_byte = {more, sign_ff, mag_ff[5:0]};
               mag_in          = mag_ff >> 6;
            end else begin
               rsp_in.out_byte = {more, mag_ff[6:0]};
               mag_in          = mag_ff >> 7;
            end
            rsp_in.last     = byte_last;
            rsp_in.overflow = 1'b0;
            first_in        = 1'b0;
            tot_left_in     = tot_left_ff - CNT_W'(1);
            emit_left_in    = emit_left_ff - CNT_W'(1);
            if (byte_last) active_in = 1'b0;
         end else begin
            // space ran out: close the item with the error word
            rsp_in.out_byte = '0;
            rsp_in.last     = 1'b1;
            rsp_in.overflow = 1'b1;
            active_in       = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff     <= first_in;
      mode_ff      <= mode_in;
      sign_ff      <= sign_in;
      ovf_ff       <= ovf_in;
      mag_ff       <= mag_in;
      tot_left_ff  <= tot_left_in;
      emit_left_ff <= emit_left_in;
      rsp_ff       <= rsp_in;
   end

endmodule

### sv/vbe_checker.sv
// vbe_checker: port-level assertions for varint_byte_encoder.
// Depends on vbe_pkg; bound to the top level at the end of this file.
module vbe_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input vbe_pkg::vbe_rsp_type rsp_data
);
   import vbe_pkg::*;

   // hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word changed");

   // drop any result on reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // empty queue after reset takes a word at once
   a_reset_ready: assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("input stalled right after reset");

   // error word closes the item and carries no byte
   a_ovf_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.overflow |-> rsp_data.last && (rsp_data.out_byte == '0))
      else $error("malformed error word");

   // continuation bit set exactly on bytes that are not the last word
   a_cont_bit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.overflow |-> rsp_data.out_byte[7] == !rsp_data.last)
      else $error("continuation bit disagrees with last");

endmodule

bind varint_byte_encoder vbe_checker u_vbe_checker (.*);

### sim/varint_byte_encoder_tb.sv
// varint_byte_encoder_tb: self-checking bench for the varint byte encoder.
// Depends on vbe_pkg and varint_byte_encoder; runs directed and random words.
// Predicts each code byte by byte and compares the result words in order.
module varint_byte_encoder_tb;
   import vbe_pkg::*;

   localparam logic [7:0] CONT_BIT    = 8'h80;
   localparam int         LONG_HOLD   = 150;   // receiver hold-off, in cycles
   localparam int         DRAIN_WAIT  = 24;    // watch for stray words after the drain
   localparam int         SHOW_LIMIT  = 10;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   vbe_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   vbe_rsp_type rsp_data;

   // expected result words, oldest first
   vbe_rsp_type code_q[$];
   int          mismatches = 0;
   int          words_seen = 0;
   // no_gaps turns off idling on both sides; hold_req asks the receiver
   // for one long hold-off
   bit          no_gaps    = 1'b0;
   bit          hold_req   = 1'b0;

   varint_byte_encoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Mostly no gap, some short ones, a few long ones.
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75)
         return 0;
      else if (r < 93)
         return $urandom_range(1, 3);
      else if (r < 99)
         return $urandom_range(4, 12);
      else
         return $urandom_range(20, 60);
   endfunction

   // Work out the code for one accepted word and queue its result words.
   // Unsigned: 7 bits per byte. Signed: sign in bit 6 of the first byte with
   // 6 magnitude bits, then 7 bits per byte; -2^63 has magnitude 2^63.
   // If the code does not fit, send what fits, then one overflow word.
   task automatic encode_varint(input vbe_req_type w);
      logic [7:0]  code[MAX_BYTES];
      logic [63:0] rest;
      logic        neg;
      int          n;
      int          room;
      vbe_rsp_type o;
      if (w.req_type == MODE_UNSIGNED) begin
         rest    = w.value;
         code[0] = ((rest > 64'(GROUP7_MASK)) ? CONT_BIT : 8'h00)
                   | (rest[7:0] & GROUP7_MASK);
         rest    = rest >> 7;
      end else begin
         neg     = w.value[63];
         rest    = neg ? (~w.value + 64'd1) : w.value;
         code[0] = ((rest > 64'(GROUP6_MASK)) ? CONT_BIT : 8'h00)
                   | (neg ? SIGN_BIT : 8'h00)
                   | (rest[7:0] & GROUP6_MASK);
         rest    = rest >> 6;
      end
      n = 1;
      while (rest != 64'd0 && n < MAX_BYTES) begin
         code[n] = ((rest > 64'(GROUP7_MASK)) ? CONT_BIT : 8'h00)
                   | (rest[7:0] & GROUP7_MASK);
         rest    = rest >> 7;
         n++;
      end
      room = int'(w.space_left);
      for (int k = 0; k < n && k < room; k++) begin
         o.out_byte = code[k];
         o.last     = (n <= room) && (k == n - 1);
         o.overflow = 1'b0;
         code_q.push_back(o);
      end
      if (n > room) begin
         o.out_byte = 8'h00;
         o.last     = 1'b1;
         o.overflow = 1'b1;
         code_q.push_back(o);
      end
   endtask

   // Offer one word after a random gap; hold it until accepted, then
   // queue its expected results. Drive only at the falling edge.
   task automatic send_word(input logic mode, input logic [63:0] value,
                            input int space);
      int gap;
      gap = no_gaps ? 0 : gap_len();
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid           <= 1'b1;
      req_data.req_type   <= mode;
      req_data.value      <= value;
      req_data.space_left <= SPACE_W'(space);
      // accept at the first rising edge with stall low
      do
         @(posedge clock);
      while (req_stall);
      encode_varint('{req_type: mode, value: value, space_left: SPACE_W'(space)});
   endtask

   // Lower valid and wait until every queued result word has come back.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (code_q.size() != 0)
         @(posedge clock);
   endtask

   // Random value with a random number of significant bits; invert some so
   // that signed mode sees short negative values too.
   function automatic logic [63:0] rand_value();
      logic [63:0] x;
      x = {$urandom(), $urandom()};
      x = x >> $urandom_range(0, 63);
      if ($urandom_range(0, 3) == 0)
         x = ~x;
      return x;
   endfunction

   // Mostly room for a few bytes, so overflow is common; sometimes the
   // whole 13-bit range.
   function automatic int rand_space();
      if ($urandom_range(0, 99) < 80)
         return $urandom_range(0, 11);
      else
         return $urandom_range(0, 8191);
   endfunction

   task automatic test_unsigned_edges();
      send_word(MODE_UNSIGNED, 64'd0, 1);
      send_word(MODE_UNSIGNED, 64'd127, 4);
      send_word(MODE_UNSIGNED, 64'd128, 4);
      send_word(MODE_UNSIGNED, 64'd16383, 4);
      send_word(MODE_UNSIGNED, 64'd16384, 4);
      send_word(MODE_UNSIGNED, '1, 10);
   endtask

   task automatic test_signed_edges();
      send_word(MODE_SIGNED, 64'd0, 1);
      send_word(MODE_SIGNED, 64'd63, 2);
      send_word(MODE_SIGNED, 64'd64, 2);
      send_word(MODE_SIGNED, '1, 2);                       // -1
      send_word(MODE_SIGNED, -64'sd64, 2);
      send_word(MODE_SIGNED, -64'sd65, 2);
      send_word(MODE_SIGNED, 64'h8000_0000_0000_0000, 12); // most negative
      send_word(MODE_SIGNED, 64'h7fff_ffff_ffff_ffff, 10);
   endtask

   task automatic test_space_limits();
      send_word(MODE_UNSIGNED, 64'd0, 0);      // no room at all
      send_word(MODE_SIGNED, 64'd5, 0);
      send_word(MODE_UNSIGNED, 64'd300000, 1); // partial code, then error
      send_word(MODE_UNSIGNED, '1, 9);         // one byte short
      send_word(MODE_SIGNED, 64'h8000_0000_0000_0000, 9);
      send_word(MODE_UNSIGNED, '1, 8191);      // full 13-bit count
      send_word(MODE_SIGNED, 64'hffff_ffff_ffff_fffe, 4096);
   endtask

   task automatic test_random(input int count);
      for (int i = 0; i < count; i++) begin
         // run a stretch with no idling on either side
         no_gaps = (i >= count / 2) && (i < count / 2 + 40);
         send_word(1'($urandom_range(0, 1)), rand_value(), rand_space());
      end
      no_gaps = 1'b0;
   endtask

   // Hold the receiver off while words keep coming, so the queue fills and
   // the input stalls.
   task automatic test_backpressure();
      hold_req = 1'b1;
      no_gaps  = 1'b1;
      for (int i = 0; i < 12; i++)
         send_word(1'($urandom_range(0, 1)), {$urandom(), $urandom()}, 10);
      no_gaps = 1'b0;
   endtask

   // Pause the sender until all results are back, then resume.
   task automatic test_drain_pause();
      for (int i = 0; i < 4; i++)
         send_word(1'($urandom_range(0, 1)), rand_value(), rand_space());
      wait_drained();
      for (int i = 0; i < 4; i++)
         send_word(1'($urandom_range(0, 1)), rand_value(), rand_space());
   endtask

   // Receiver: random stall bursts, plus one long hold-off on request.
   initial begin : rsp_side
      int run;
      run       = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            run      = LONG_HOLD;
         end else if (run == 0 && !no_gaps) begin
            run = gap_len();
         end
         if (run > 0) begin
            rsp_stall <= 1'b1;
            run--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Check each accepted result word against the oldest expectation.
   always @(posedge clock) begin
      vbe_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         words_seen++;
         if (code_q.size() == 0) begin
            mismatches++;
            if (mismatches <= SHOW_LIMIT)
               $display("ERROR word %0d: nothing expected, actual byte=%02h last=%b ovf=%b",
                        words_seen, rsp_data.out_byte, rsp_data.last,
                        rsp_data.overflow);
         end else begin
            want = code_q.pop_front();
            if (rsp_data.out_byte !== want.out_byte || rsp_data.last !== want.last
                || rsp_data.overflow !== want.overflow) begin
               mismatches++;
               if (mismatches <= SHOW_LIMIT)
                  $display("ERROR word %0d: expected byte=%02h last=%b ovf=%b, actual byte=%02h last=%b ovf=%b",
                           words_seen, want.out_byte, want.last, want.overflow,
                           rsp_data.out_byte, rsp_data.last, rsp_data.overflow);
            end
         end
      end
   end

   // Hard limit, far beyond the slowest correct run.
   initial begin
      #(64'd20_000_000);
      $display("Mismatches found");
      $finish;
   end

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_unsigned_edges();
      test_signed_edges();
      test_space_limits();
      test_backpressure();
      test_drain_pause();
      test_random(300);

      // let the last results drain, then watch for strays
      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0 && code_q.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
